// File: rtl/core/pulse_width_code_transmitter_macros.svh
// Assertion macros for the pulse width code transmitter checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef PULSE_WIDTH_CODE_TRANSMITTER_MACROS_SVH
`define PULSE_WIDTH_CODE_TRANSMITTER_MACROS_SVH

// Property that must hold in every cycle outside reset.
`define PWCT_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define PWCT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/pwct_pkg.sv
// Shared types and constants for the pulse width code transmitter.
// No dependencies.
package pwct_pkg;

   localparam int DUR_W = 16;   // duration register width
   localparam int BPF_W = 6;    // bits_per_frame register width
   localparam int REP_W = 8;    // frame_repeats register width
   localparam int CODE_W = 32;  // code word width on the input stream
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   // register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_START_HIGH = 3'd0;
   localparam logic [2:0] REG_START_LOW  = 3'd1;
   localparam logic [2:0] REG_ZERO_HIGH  = 3'd2;
   localparam logic [2:0] REG_ZERO_LOW   = 3'd3;
   localparam logic [2:0] REG_ONE_HIGH   = 3'd4;
   localparam logic [2:0] REG_ONE_LOW    = 3'd5;
   localparam logic [2:0] REG_BITS       = 3'd6;
   localparam logic [2:0] REG_REPEATS    = 3'd7;

   // item kinds
   localparam logic KIND_TICK  = 1'b0;
   localparam logic KIND_START = 1'b1;

   // transmit phases
   localparam logic [2:0] PH_IDLE       = 3'd0;
   localparam logic [2:0] PH_START_HIGH = 3'd1;
   localparam logic [2:0] PH_START_LOW  = 3'd2;
   localparam logic [2:0] PH_BIT_HIGH   = 3'd3;
   localparam logic [2:0] PH_BIT_LOW    = 3'd4;

   typedef struct packed {
      logic [DUR_W-1:0] start_high;
      logic [DUR_W-1:0] start_low;
      logic [DUR_W-1:0] zero_high;
      logic [DUR_W-1:0] zero_low;
      logic [DUR_W-1:0] one_high;
      logic [DUR_W-1:0] one_low;
      logic [BPF_W-1:0] bits;
      logic [REP_W-1:0] repeats;
   } cfg_type;

   // line_level in bit 0
   typedef struct packed {
      logic rejected;
      logic finished;
      logic busy_res;
      logic line_level;
   } rsp_type;

endpackage

// File: rtl/core/pwct_regs.sv
// Configuration register file with an APB-style write/read port.
// Depends on pwct_pkg.
module pwct_regs (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [pwct_pkg::ADDR_W-1:0]    csr_paddr,
   input  logic [pwct_pkg::DATA_W-1:0]    csr_pwdata,
   output logic [pwct_pkg::DATA_W-1:0]    csr_prdata,
   output logic                           csr_pready,
   output pwct_pkg::cfg_type              cfg
);
   import pwct_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [2:0] idx;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign idx = csr_paddr[4:2];
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_START_HIGH: cfg_in.start_high = csr_pwdata[DUR_W-1:0];
            REG_START_LOW:  cfg_in.start_low  = csr_pwdata[DUR_W-1:0];
            REG_ZERO_HIGH:  cfg_in.zero_high  = csr_pwdata[DUR_W-1:0];
            REG_ZERO_LOW:   cfg_in.zero_low   = csr_pwdata[DUR_W-1:0];
            REG_ONE_HIGH:   cfg_in.one_high   = csr_pwdata[DUR_W-1:0];
            REG_ONE_LOW:    cfg_in.one_low    = csr_pwdata[DUR_W-1:0];
            REG_BITS:       cfg_in.bits       = csr_pwdata[BPF_W-1:0];
            REG_REPEATS:    cfg_in.repeats    = csr_pwdata[REP_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_START_HIGH: csr_prdata = DATA_W'(cfg_ff.start_high);
         REG_START_LOW:  csr_prdata = DATA_W'(cfg_ff.start_low);
         REG_ZERO_HIGH:  csr_prdata = DATA_W'(cfg_ff.zero_high);
         REG_ZERO_LOW:   csr_prdata = DATA_W'(cfg_ff.zero_low);
         REG_ONE_HIGH:   csr_prdata = DATA_W'(cfg_ff.one_high);
         REG_ONE_LOW:    csr_prdata = DATA_W'(cfg_ff.one_low);
         REG_BITS:       csr_prdata = DATA_W'(cfg_ff.bits);
         REG_REPEATS:    csr_prdata = DATA_W'(cfg_ff.repeats);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_high <= DUR_W'(280);
         cfg_ff.start_low  <= DUR_W'(10000);
         cfg_ff.zero_high  <= DUR_W'(280);
         cfg_ff.zero_low   <= DUR_W'(1000);
         cfg_ff.one_high   <= DUR_W'(920);
         cfg_ff.one_low    <= DUR_W'(360);
         cfg_ff.bits       <= BPF_W'(24);
         cfg_ff.repeats    <= REP_W'(10);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/core/pwct_engine.sv
// Transmit sequencer: phase, tick counter, bit and repeat counters.
// Advances once per accepted item and produces that item's result. Depends on pwct_pkg.
module pwct_engine #(
   parameter int MAX_CODE_BITS = 32,
   parameter int DURATION_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_acc,
   input  logic                        in_kind,
   input  logic [pwct_pkg::CODE_W-1:0] in_code,
   input  pwct_pkg::cfg_type           cfg,
   output pwct_pkg::rsp_type           result
);
   import pwct_pkg::*;

   localparam int BPW  = $clog2(MAX_CODE_BITS + 1);
   localparam int IW   = (MAX_CODE_BITS > 1) ? $clog2(MAX_CODE_BITS) : 1;
   localparam int DWW  = (DURATION_BITS > DUR_W) ? DURATION_BITS : DUR_W;
   localparam int CWW  = (MAX_CODE_BITS > CODE_W) ? MAX_CODE_BITS : CODE_W;
   localparam int CMPW = (BPW > BPF_W) ? BPW + 1 : BPF_W + 1;

   logic [2:0]               phase_ff, phase_in;
   logic [DURATION_BITS-1:0] ticks_ff, ticks_in;
   logic [BPW-1:0]           bitpos_ff, bitpos_in;
   logic [REP_W-1:0]         reps_ff, reps_in;
   logic [MAX_CODE_BITS-1:0] code_ff, code_in;

   logic [BPW-1:0]           frame_bits;
   logic [BPW-1:0]           next_pos;
   logic [CWW-1:0]           code_wide;
   logic                     fin;

   // duration masked to the counter width; zero lasts one tick
   function automatic logic [DURATION_BITS-1:0] dur(input logic [DUR_W-1:0] v);
      logic [DWW-1:0]           w;
      logic [DURATION_BITS-1:0] d;
      w = DWW'(v);
      d = w[DURATION_BITS-1:0];
      if (d == '0) d = DURATION_BITS'(1);
      return d;
   endfunction

   function automatic logic bit_at(input logic [MAX_CODE_BITS-1:0] c,
                                   input logic [BPW-1:0] pos);
      logic [BPW-1:0] p;
      p = pos - BPW'(1);
      return c[p[IW-1:0]];
   endfunction

   always_comb begin
      if (CMPW'(cfg.bits) > CMPW'(MAX_CODE_BITS)) frame_bits = BPW'(MAX_CODE_BITS);
      else frame_bits = BPW'(cfg.bits);
   end

   assign code_wide = CWW'(in_code);
   assign next_pos  = (bitpos_ff != '0) ? bitpos_ff - BPW'(1) : '0;

   always_comb begin
      phase_in  = phase_ff;
      ticks_in  = ticks_ff;
      bitpos_in = bitpos_ff;
      reps_in   = reps_ff;
      code_in   = code_ff;
      fin       = 1'b0;
      result    = '0;

      if (in_kind == KIND_START) begin
         if (phase_ff != PH_IDLE) begin
            result.rejected = 1'b1;
         end else begin
            code_in   = code_wide[MAX_CODE_BITS-1:0];
            reps_in   = (cfg.repeats == '0) ? REP_W'(1) : cfg.repeats;
            bitpos_in = frame_bits;
            phase_in  = PH_START_HIGH;
            ticks_in  = dur(cfg.start_high);
         end
      end else if (phase_ff != PH_IDLE) begin
         result.line_level = (phase_ff == PH_START_HIGH) || (phase_ff == PH_BIT_HIGH);
         if (ticks_ff > DURATION_BITS'(1)) begin
            ticks_in = ticks_ff - DURATION_BITS'(1);
         end else begin
            // pick the position that ends this phase, then either next bit or frame end
            if (phase_ff == PH_BIT_LOW) bitpos_in = next_pos;
            unique case (phase_ff)
               PH_START_HIGH: begin
                  phase_in = PH_START_LOW;
                  ticks_in = dur(cfg.start_low);
               end
               PH_BIT_HIGH: begin
                  phase_in = PH_BIT_LOW;
                  ticks_in = dur(bit_at(code_ff, bitpos_ff) ? cfg.one_low : cfg.zero_low);
               end
               PH_START_LOW, PH_BIT_LOW: begin
                  if (bitpos_in != '0) begin
                     phase_in = PH_BIT_HIGH;
                     ticks_in = dur(bit_at(code_ff, bitpos_in) ? cfg.one_high
                                                                : cfg.zero_high);
                  end else if (reps_ff > REP_W'(1)) begin
                     reps_in   = reps_ff - REP_W'(1);
                     bitpos_in = frame_bits;
                     phase_in  = PH_START_HIGH;
                     ticks_in  = dur(cfg.start_high);
                  end else begin
                     reps_in   = '0;
                     bitpos_in = '0;
                     phase_in  = PH_IDLE;
                     ticks_in  = '0;
                     fin       = 1'b1;
                  end
               end
               default: phase_in = PH_IDLE;
            endcase
         end
      end

      result.finished = fin;
      result.busy_res = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         ticks_ff  <= '0;
         bitpos_ff <= '0;
         reps_ff   <= '0;
      end else if (in_acc) begin
         phase_ff  <= phase_in;
         ticks_ff  <= ticks_in;
         bitpos_ff <= bitpos_in;
         reps_ff   <= reps_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_acc) code_ff <= code_in;
   end

endmodule

// File: rtl/core/pwct_outq.sv
// Two-entry result buffer between the sequencer and the result stream.
// Lets a new item in while an older result is still waiting. Depends on pwct_pkg.
module pwct_outq (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  pwct_pkg::rsp_type din,
   output logic              has_room,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output pwct_pkg::rsp_type rsp_item
);
   import pwct_pkg::*;

   rsp_type    ent0_ff, ent0_in;
   rsp_type    ent1_ff, ent1_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign has_room   = (count_ff != 2'd2);
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_item   = ent0_ff;
   assign pop        = rsp_tvalid & rsp_tready;

   always_comb begin
      ent0_in  = ent0_ff;
      ent1_in  = ent1_ff;
      count_in = count_ff;
      unique case ({push, pop})
         2'b10: begin
            if (count_ff == 2'd0) ent0_in = din;
            else ent1_in = din;
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            ent0_in  = ent1_ff;
            count_in = count_ff - 2'd1;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               ent0_in = din;
            end else begin
               ent0_in = ent1_ff;
               ent1_in = din;
            end
         end
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= 2'd0;
      else count_ff <= count_in;
   end

   always_ff @(posedge clock) begin
      ent0_ff <= ent0_in;
      ent1_ff <= ent1_in;
   end

endmodule

// File: rtl/core/pulse_width_code_transmitter.sv
// Throughput: one item per cycle while the result buffer has room; results are
// registered there in order. The sequencer updates its counters in the accepting
// cycle, and the two-entry result buffer holds results while rsp stalls.
// Reset (synchronous): transmitter idle, buffer empty, registers at their defaults.
// Top level: register file, sequencer and result buffer. Depends on pwct_pkg.
module pulse_width_code_transmitter #(
   parameter int MAX_CODE_BITS = 32,
   parameter int DURATION_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [pwct_pkg::CODE_W-1:0] req_tdata,   // [31:0] code_word
   input  logic                        req_tuser,   // [0] kind
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [0] line_level, [1] busy_res, [2] finished, [3] rejected, [7:4] zero
   output logic [7:0]                  rsp_tdata,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [pwct_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [pwct_pkg::DATA_W-1:0] csr_pwdata,
   output logic [pwct_pkg::DATA_W-1:0] csr_prdata,
   output logic                        csr_pready
);
   import pwct_pkg::*;

   cfg_type cfg;
   rsp_type result;
   rsp_type rsp_item;
   logic    in_acc;
   logic    has_room;

   assign req_tready = has_room;
   assign in_acc     = req_tvalid & req_tready;
   assign rsp_tdata  = 8'(rsp_item);

   pwct_regs u_regs (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pwct_engine #(
      .MAX_CODE_BITS (MAX_CODE_BITS),
      .DURATION_BITS (DURATION_BITS)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .in_acc  (in_acc),
      .in_kind (req_tuser),
      .in_code (req_tdata),
      .cfg     (cfg),
      .result  (result)
   );

   pwct_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (in_acc),
      .din        (result),
      .has_room   (has_room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

endmodule

// File: rtl/core/pwct_checker.sv
// Port-level checks for the pulse width code transmitter, bound to the top level.
// Depends on pwct_pkg and pulse_width_code_transmitter_macros.svh.
`include "pulse_width_code_transmitter_macros.svh"

module pwct_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [7:0]                  rsp_tdata,
   input logic                        csr_pready
);
   import pwct_pkg::*;

   `PWCT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")
   `PWCT_ASSERT(a_fin_idle, clock, reset, !(rsp_tvalid && rsp_tdata[2]) || !rsp_tdata[1], "finished while still busy")
   `PWCT_ASSERT(a_rej_busy, clock, reset, !(rsp_tvalid && rsp_tdata[3]) || (rsp_tdata[1] && !rsp_tdata[0] && !rsp_tdata[2]), "rejected start with bad flags")
   `PWCT_ASSERT(a_level_busy, clock, reset, !(rsp_tvalid && rsp_tdata[0]) || rsp_tdata[1] || rsp_tdata[2], "line high while idle")
   `PWCT_ASSERT(a_pready, clock, reset, csr_pready, "csr_pready low")

endmodule

bind pulse_width_code_transmitter pwct_checker u_pwct_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);

// File: verif/pulse_width_code_transmitter_tb.sv
// Self-checking testbench for the pulse width code transmitter: drives ticks and
// start transfers, reprograms the registers between phases and checks every
// result against a cycle-free model of the line sequencer. Depends on pwct_pkg.
`timescale 1ns / 1ps

module pulse_width_code_transmitter_tb;
   import pwct_pkg::*;

   localparam int MAX_CODE_BITS = 32;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 4;

   // Line sequencer model plus the queue of results it still owes the checker.
   class line_scoreboard;
      cfg_type regs;
      logic [CODE_W-1:0] code_q;
      int unsigned bits_left;
      int unsigned frames_left;
      logic [2:0] ph;
      int unsigned ticks_rem;
      rsp_type expected_rsp[$];
      int unsigned errors, n_items, n_results, n_started, n_refused, n_done;

      function new();
         regs.start_high = 16'd280;
         regs.start_low  = 16'd10000;
         regs.zero_high  = 16'd280;
         regs.zero_low   = 16'd1000;
         regs.one_high   = 16'd920;
         regs.one_low    = 16'd360;
         regs.bits       = 6'd24;
         regs.repeats    = 8'd10;
         code_q = '0;
         bits_left = 0;
         frames_left = 0;
         ph = PH_IDLE;
         ticks_rem = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [DATA_W-1:0] val);
         case (idx)
            REG_START_HIGH: regs.start_high = val[DUR_W-1:0];
            REG_START_LOW:  regs.start_low  = val[DUR_W-1:0];
            REG_ZERO_HIGH:  regs.zero_high  = val[DUR_W-1:0];
            REG_ZERO_LOW:   regs.zero_low   = val[DUR_W-1:0];
            REG_ONE_HIGH:   regs.one_high   = val[DUR_W-1:0];
            REG_ONE_LOW:    regs.one_low    = val[DUR_W-1:0];
            REG_BITS:       regs.bits       = val[BPF_W-1:0];
            REG_REPEATS:    regs.repeats    = val[REP_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [DATA_W-1:0] reg_value(logic [2:0] idx);
         case (idx)
            REG_START_HIGH: return DATA_W'(regs.start_high);
            REG_START_LOW:  return DATA_W'(regs.start_low);
            REG_ZERO_HIGH:  return DATA_W'(regs.zero_high);
            REG_ZERO_LOW:   return DATA_W'(regs.zero_low);
            REG_ONE_HIGH:   return DATA_W'(regs.one_high);
            REG_ONE_LOW:    return DATA_W'(regs.one_low);
            REG_BITS:       return DATA_W'(regs.bits);
            default:        return DATA_W'(regs.repeats);
         endcase
      endfunction

      // a zero duration still occupies one tick
      function int unsigned span(logic [DUR_W-1:0] v);
         return (v == 0) ? 1 : v;
      endfunction

      function int unsigned frame_width();
         return (regs.bits > MAX_CODE_BITS) ? MAX_CODE_BITS : regs.bits;
      endfunction

      function logic code_bit();
         return code_q[bits_left - 1];
      endfunction

      function void enter_bit();
         ph = PH_BIT_HIGH;
         ticks_rem = span(code_bit() ? regs.one_high : regs.zero_high);
      endfunction

      // returns 1 when the last frame has gone out
      function logic next_frame();
         if (frames_left > 1) begin
            frames_left--;
            bits_left = frame_width();
            ph = PH_START_HIGH;
            ticks_rem = span(regs.start_high);
            return 1'b0;
         end
         frames_left = 0;
         bits_left = 0;
         ph = PH_IDLE;
         ticks_rem = 0;
         n_done++;
         return 1'b1;
      endfunction

      function logic transmitting();
         return ph != PH_IDLE;
      endfunction

      function int pending();
         return expected_rsp.size();
      endfunction

      function void note_input(logic kind, logic [CODE_W-1:0] code);
         rsp_type r;
         r = '0;
         n_items++;
         if (kind == KIND_START) begin
            if (ph != PH_IDLE) begin
               r.rejected = 1'b1;
               n_refused++;
            end else begin
               code_q = code;
               frames_left = (regs.repeats == 0) ? 1 : regs.repeats;
               bits_left = frame_width();
               ph = PH_START_HIGH;
               ticks_rem = span(regs.start_high);
               n_started++;
            end
         end else if (ph != PH_IDLE) begin
            r.line_level = (ph == PH_START_HIGH) || (ph == PH_BIT_HIGH);
            if (ticks_rem > 1) begin
               ticks_rem--;
            end else begin
               case (ph)
                  PH_START_HIGH: begin
                     ph = PH_START_LOW;
                     ticks_rem = span(regs.start_low);
                  end
                  PH_START_LOW: begin
                     if (bits_left > 0) enter_bit();
                     else r.finished = next_frame();
                  end
                  PH_BIT_HIGH: begin
                     ph = PH_BIT_LOW;
                     ticks_rem = span(code_bit() ? regs.one_low : regs.zero_low);
                  end
                  default: begin
                     if (bits_left > 0) bits_left--;
                     if (bits_left > 0) enter_bit();
                     else r.finished = next_frame();
                  end
               endcase
            end
         end
         r.busy_res = (ph != PH_IDLE);
         expected_rsp.push_back(r);
      endfunction

      task report(string what);
         errors++;
         if (errors <= 40) $display("[%0t] MISMATCH: %s", $time, what);
      endtask

      task check_result(logic [7:0] data);
         rsp_type got, want;
         got = data[3:0];
         if (expected_rsp.size() == 0) begin
            report($sformatf("result %h with nothing outstanding", data));
            return;
         end
         want = expected_rsp.pop_front();
         n_results++;
         if (got.line_level !== want.line_level)
            report($sformatf("result %0d line_level %b, want %b", n_results, got.line_level,
                             want.line_level));
         if (got.busy_res !== want.busy_res)
            report($sformatf("result %0d busy_res %b, want %b", n_results, got.busy_res,
                             want.busy_res));
         if (got.finished !== want.finished)
            report($sformatf("result %0d finished %b, want %b", n_results, got.finished,
                             want.finished));
         if (got.rejected !== want.rejected)
            report($sformatf("result %0d rejected %b, want %b", n_results, got.rejected,
                             want.rejected));
         if (data[7:4] !== 4'h0)
            report($sformatf("result %0d padding bits %b", n_results, data[7:4]));
      endtask
   endclass

   logic                clock;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [CODE_W-1:0]   req_tdata = '0;   // [31:0] code_word
   logic                req_tuser = 1'b0; // [0] kind
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [7:0]          rsp_tdata;        // [0] line_level, [1] busy_res, [2] finished,
                                          // [3] rejected, [7:4] zero
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]   csr_paddr = '0;
   logic [DATA_W-1:0]   csr_pwdata = '0;
   logic [DATA_W-1:0]   csr_prdata;
   logic                csr_pready;

   line_scoreboard sb;
   bit req_gaps = 1'b1;
   bit rsp_gaps = 1'b1;
   bit hold_rsp = 1'b0;
   int unsigned n_writes = 0;
   int unsigned cycle_count = 0;

   pulse_width_code_transmitter i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count == CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, sb.pending());
      $display("pulse_width_code_transmitter_tb: done, errors");
      $finish;
   end

   // result side: random stalls, plus one long hold-off when asked
   initial begin
      int stall;
      wait (reset == 1'b0);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         stall = rsp_gaps ? $urandom_range(0, 5) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_tdata);
      end
   end

   task automatic send_item(input logic kind, input logic [CODE_W-1:0] code);
      int gap;
      gap = req_gaps ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= code;
      do @(posedge clock); while (!req_tready);
      sb.note_input(kind, code);
   endtask

   // stop offering and wait until every result has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // write one register, then read it back
   task automatic set_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      sb.set_reg(idx, val);
      n_writes++;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== sb.reg_value(idx))
         sb.report($sformatf("register %0d reads %h, want %h", idx, csr_prdata,
                             sb.reg_value(idx)));
   endtask

   // upper bits of each write are junk half the time; the block must mask them
   task automatic load_profile(input logic [15:0] sh, sl, zh, zl, oh, ol,
                               input logic [5:0] bits, input logic [7:0] reps);
      logic [15:0] hi;
      hi = $urandom_range(0, 1) ? 16'($urandom) : 16'h0;
      set_reg(REG_START_HIGH, {hi, sh});
      set_reg(REG_START_LOW,  {hi, sl});
      set_reg(REG_ZERO_HIGH,  {hi, zh});
      set_reg(REG_ZERO_LOW,   {hi, zl});
      set_reg(REG_ONE_HIGH,   {hi, oh});
      set_reg(REG_ONE_LOW,    {hi, ol});
      set_reg(REG_BITS,       {hi, hi[9:0], bits});
      set_reg(REG_REPEATS,    {hi, hi[7:0], reps});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic random_profile();
      logic [15:0] d [6];
      logic [5:0] bits;
      logic [7:0] reps;
      foreach (d[i])
         d[i] = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 24))
                                            : 16'($urandom_range(0, 3));
      bits = ($urandom_range(0, 9) < 2) ? 6'($urandom_range(28, 63))
                                        : 6'($urandom_range(0, 6));
      reps = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(4, 8))
                                         : 8'($urandom_range(0, 3));
      load_profile(d[0], d[1], d[2], d[3], d[4], d[5], bits, reps);
   endtask

   function automatic logic [CODE_W-1:0] pick_code();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return CODE_W'($urandom);
      endcase
   endfunction

   task automatic finish_transmission();
      while (sb.transmitting()) send_item(KIND_TICK, CODE_W'($urandom));
   endtask

   // mostly complete transmissions, with stray starts while busy and idle ticks between
   task automatic run_traffic(input int unsigned budget);
      logic kind;
      for (int unsigned n = 0; n < budget; n++) begin
         if (!sb.transmitting())
            kind = ($urandom_range(0, 3) != 0) ? KIND_START : KIND_TICK;
         else
            kind = ($urandom_range(0, 15) == 0) ? KIND_START : KIND_TICK;
         send_item(kind, pick_code());
      end
   endtask

   initial begin
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // power-on timings: idle tick, start, start while busy, a few ticks
      send_item(KIND_TICK, '1);
      send_item(KIND_START, '1);
      send_item(KIND_START, '0);
      repeat (4) send_item(KIND_TICK, CODE_W'($urandom));
      drain();

      // new timings land mid-transmission: zero durations, no bits, zero repeats
      load_profile(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 6'd0, 8'd0);
      finish_transmission();
      send_item(KIND_START, '0);
      finish_transmission();
      drain();

      // more bits than the code holds
      load_profile(16'd1, 16'd2, 16'd1, 16'd2, 16'd2, 16'd0, 6'd63, 8'd1);
      send_item(KIND_START, 32'h8000_0001);
      finish_transmission();
      send_item(KIND_START, '1);
      finish_transmission();
      drain();

      load_profile(16'd0, 16'd1, 16'd2, 16'd0, 16'd0, 16'd3, 6'd32, 8'd2);
      send_item(KIND_START, CODE_W'($urandom));
      finish_transmission();
      drain();

      // most repeats, start pulse only
      load_profile(16'd1, 16'd0, 16'd1, 16'd1, 16'd1, 16'd1, 6'd0, 8'd255);
      send_item(KIND_START, '0);
      finish_transmission();
      drain();

      // no idle cycles on either side for a whole transmission
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      load_profile(16'd3, 16'd1, 16'd2, 16'd4, 16'd5, 16'd2, 6'd8, 8'd2);
      send_item(KIND_START, CODE_W'($urandom));
      finish_transmission();
      drain();

      for (int p = 0; p < 12; p++) begin
         random_profile();
         req_gaps = ($urandom_range(0, 3) != 0);
         rsp_gaps = ($urandom_range(0, 3) != 0);
         if (p == 3) begin
            // receiver holds off while the sender keeps offering
            req_gaps = 1'b0;
            hold_rsp = 1'b1;
         end
         run_traffic(30);
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
      $display("sent %0d transfers: %0d transmissions started, %0d starts refused while busy",
               sb.n_items, sb.n_started, sb.n_refused);
      $display("%0d results checked, %0d transmissions completed, %0d register writes",
               sb.n_results, sb.n_done, n_writes);
      if (sb.errors == 0) begin
         $display("pulse_width_code_transmitter_tb: done, clean");
      end else begin
         $display("pulse_width_code_transmitter_tb: done, errors");
      end
      $finish;
   end

endmodule
